[sv/proper_divisor_sum_top_defines.svh]
// assertion macros for the proper divisor sum block
`ifndef PROPER_DIVISOR_SUM_TOP_DEFINES_SVH
`define PROPER_DIVISOR_SUM_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define PDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// checked on every edge including reset
`define PDS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define PDS_ASSERT(lbl, prop, msg)
`define PDS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[sv/pds_pkg.sv]
// shared widths, limits, opcodes and control types for the proper divisor sum block
package pds_pkg;
   localparam int NUM_W  = 54;
   localparam int SUM_W  = 57;
   localparam int CAND_W = 28;
   localparam int SQ_W   = 56;
   localparam int CNT_W  = $clog2(SUM_W);

   // largest trial candidate
   localparam logic [31:0] TRIAL_LIMIT = 32'd134217728;

   // serial unit operations
   localparam logic OP_DIV = 1'b0;
   localparam logic OP_MUL = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;
endpackage

[sv/pds_alu.sv]
// bit-serial divide and multiply unit sharing one adder
module pds_alu import pds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  alu_cmd_type       cmd,
   input  logic [SUM_W-1:0]  opa,
   input  logic [SUM_W-1:0]  opb,
   output alu_sts_type       sts,
   output logic [SUM_W-1:0]  quot,
   output logic [SUM_W-1:0]  rslt
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]  shreg_ff, shreg_in;
   logic [SUM_W-1:0]  opnd_ff, opnd_in;

   logic [SUM_W:0]    trial;
   logic [SUM_W+1:0]  base;
   logic [SUM_W+1:0]  addend;
   logic [SUM_W+1:0]  sum;
   logic              qbit;

   // one shared adder: subtract for divide, add for multiply
   always_comb begin
      trial  = {acc_ff[SUM_W-1:0], shreg_ff[SUM_W-1]};
      if (op_ff == OP_DIV) begin
         base   = {1'b0, trial};
         addend = ~{2'b00, opnd_ff};
      end else begin
         base   = {2'b00, acc_ff[SUM_W-2:0], 1'b0};
         addend = {2'b00, opnd_ff};
      end
      sum  = base + addend + (SUM_W+2)'(op_ff == OP_DIV);
      qbit = ~sum[SUM_W+1];
   end

   // sequencing of one operation, one bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      shreg_in = shreg_ff;
      opnd_in  = opnd_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CNT_W'(SUM_W - 1);
         acc_in  = '0;
         if (cmd.op == OP_DIV) begin
            shreg_in = opa;
            opnd_in  = opb;
         end else begin
            shreg_in = opb;
            opnd_in  = opa;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            acc_in   = qbit ? sum[SUM_W:0] : trial;
            shreg_in = {shreg_ff[SUM_W-2:0], qbit};
         end else begin
            acc_in   = shreg_ff[SUM_W-1] ? {1'b0, sum[SUM_W-1:0]}
                                         : {1'b0, base[SUM_W-1:0]};
            shreg_in = {shreg_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      shreg_ff <= shreg_in;
      opnd_ff  <= opnd_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = shreg_ff;
   assign rslt     = acc_ff[SUM_W-1:0];
endmodule

[sv/proper_divisor_sum_top.sv]
// proper divisor sum by trial division over a shared bit-serial unit
//
//   channel    ports                         transfer
//   request    start, busy, req_number       start high while busy low
//   response   rsp_valid, rsp_divisor_sum    one-cycle strobe, cannot stall
//
// each candidate tested costs one serial division plus sequencing; each power of
// a prime factor adds a multiply and one more division, and each prime one more
// multiply. a zero number answers in the cycle after transfer. busy is high
// from the transaction of a nonzero number until the result strobe; synchronous
// reset returns the sequencer to idle with no result pending.
module proper_divisor_sum_top import pds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [NUM_W-1:0]  req_number,
   output logic              rsp_valid,
   output logic [SUM_W-1:0]  rsp_divisor_sum
);
`include "proper_divisor_sum_top_defines.svh"

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_MULPP   = 3'd3;
   localparam logic [2:0] ST_MULSIG  = 3'd4;
   localparam logic [2:0] ST_MULLAST = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [NUM_W-1:0]  orig_ff, orig_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  sigma_ff, sigma_in;
   logic [CAND_W-1:0] cand_ff, cand_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]  pp_ff, pp_in;
   logic [SUM_W-1:0]  psum_ff, psum_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   alu_cmd_type       alu_cmd;
   alu_sts_type       alu_sts;
   logic [SUM_W-1:0]  alu_opa, alu_opb;
   logic [SUM_W-1:0]  alu_quot, alu_rslt;
   logic [CAND_W-1:0] cand_next;
   logic [SQ_W-1:0]   sq_next;

   pds_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_opa),
      .opb   (alu_opb),
      .sts   (alu_sts),
      .quot  (alu_quot),
      .rslt  (alu_rslt)
   );

   // next candidate and its square: 2 then odd numbers
   always_comb begin
      if (cand_ff == CAND_W'(2)) begin
         cand_next = CAND_W'(3);
         sq_next   = SQ_W'(9);
      end else begin
         cand_next = cand_ff + CAND_W'(2);
         sq_next   = sq_ff + SQ_W'({cand_ff, 2'b00}) + SQ_W'(4);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      orig_in      = orig_ff;
      rem_in       = rem_ff;
      sigma_in     = sigma_ff;
      cand_in      = cand_ff;
      sq_in        = sq_ff;
      pp_in        = pp_ff;
      psum_in      = psum_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      alu_cmd      = '{start: 1'b0, op: OP_DIV};
      alu_opa      = SUM_W'(rem_ff);
      alu_opb      = SUM_W'(cand_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               orig_in  = req_number;
               rem_in   = req_number;
               sigma_in = SUM_W'(1);
               cand_in  = CAND_W'(2);
               sq_in    = SQ_W'(4);
               if (req_number == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = '0;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (32'(cand_ff) > TRIAL_LIMIT || sq_ff > SQ_W'(rem_ff)) begin
               if (rem_ff > NUM_W'(1)) begin
                  alu_cmd  = '{start: 1'b1, op: OP_MUL};
                  alu_opa  = sigma_ff;
                  alu_opb  = SUM_W'(rem_ff) + SUM_W'(1);
                  state_in = ST_MULLAST;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = sigma_ff - SUM_W'(orig_ff);
                  state_in     = ST_IDLE;
               end
            end else begin
               alu_cmd  = '{start: 1'b1, op: OP_DIV};
               hit_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (alu_sts.done) begin
               if (alu_rslt == '0) begin
                  // candidate divides: strip it and grow the power
                  rem_in  = alu_quot[NUM_W-1:0];
                  hit_in  = 1'b1;
                  alu_cmd = '{start: 1'b1, op: OP_MUL};
                  alu_opa = hit_ff ? pp_ff : SUM_W'(1);
                  alu_opb = SUM_W'(cand_ff);
                  if (!hit_ff) begin
                     psum_in = SUM_W'(1);
                  end
                  state_in = ST_MULPP;
               end else if (hit_ff) begin
                  alu_cmd  = '{start: 1'b1, op: OP_MUL};
                  alu_opa  = sigma_ff;
                  alu_opb  = psum_ff;
                  state_in = ST_MULSIG;
               end else begin
                  cand_in  = cand_next;
                  sq_in    = sq_next;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_MULPP: begin
            if (alu_sts.done) begin
               pp_in    = alu_rslt;
               psum_in  = psum_ff + alu_rslt;
               alu_cmd  = '{start: 1'b1, op: OP_DIV};
               state_in = ST_DIV;
            end
         end
         ST_MULSIG: begin
            if (alu_sts.done) begin
               sigma_in = alu_rslt;
               cand_in  = cand_next;
               sq_in    = sq_next;
               state_in = ST_CHECK;
            end
         end
         ST_MULLAST: begin
            if (alu_sts.done) begin
               sigma_in     = alu_rslt;
               rsp_valid_in = 1'b1;
               rsp_sum_in   = alu_rslt - SUM_W'(orig_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      orig_ff    <= orig_in;
      rem_ff     <= rem_in;
      sigma_ff   <= sigma_in;
      cand_ff    <= cand_in;
      sq_ff      <= sq_in;
      pp_ff      <= pp_in;
      psum_ff    <= psum_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_divisor_sum = rsp_sum_ff;

   // checks
   `PDS_ASSERT(a_alu_free, alu_cmd.start |-> !alu_sts.busy, "serial unit started while busy")
   `PDS_ASSERT(a_sq_track, (state_ff == ST_CHECK) |-> (sq_ff == SQ_W'(cand_ff) * SQ_W'(cand_ff)), "square out of step with candidate")
   `PDS_ASSERT(a_div_cand, (state_ff == ST_DIV) |-> (cand_ff >= CAND_W'(2)), "division by a candidate below two")
   `PDS_ASSERT(a_done_wait, alu_sts.done |-> (state_ff == ST_DIV || state_ff == ST_MULPP || state_ff == ST_MULSIG || state_ff == ST_MULLAST), "serial unit finished with no waiter")
   `PDS_ASSERT_RST(a_reset_idle, reset |=> (!busy && !rsp_valid), "not idle after reset")
endmodule
